// ===== rtl/rmc_pkg.sv =====
`default_nettype none
package rmc_pkg;

   localparam int MAX_SIDE_DEF  = 64;
   localparam int MAX_WALLS_DEF = 8192;
   localparam int MAX_ROOMS_DEF = 4096;

   localparam int CSR_DATA_W = 7;
   localparam int WORD_W     = 32;
   localparam int DCNT_W     = 5;

   localparam logic [CSR_DATA_W-1:0] HEIGHT_RST = 7'd8;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RST  = 7'd8;

   localparam logic CSR_HEIGHT = 1'b0;
   localparam logic CSR_WIDTH  = 1'b1;

   typedef struct packed {
      logic clr_step;
      logic capture;
      logic resp_blank;
      logic div_load_word;
      logic div_load_wall;
      logic div_step;
      logic wall_read;
      logic rooms;
      logic find_load_first;
      logic find_load_second;
      logic find_step;
      logic save_root1;
      logic union_do;
      logic shift_init;
      logic shift_step;
      logic count_dec;
   } cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic clr_last;
      logic done_hit;
      logic list_empty;
      logic div_last;
      logic find_stop;
      logic maze_done;
      logic shift_done;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/rmc_ram.sv =====
`default_nettype none
module rmc_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 8192
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/rmc_dpath.sv =====
`default_nettype none
module rmc_dpath #(
   parameter int MAX_SIDE  = rmc_pkg::MAX_SIDE_DEF,
   parameter int MAX_WALLS = rmc_pkg::MAX_WALLS_DEF,
   parameter int MAX_ROOMS = rmc_pkg::MAX_ROOMS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write_enable,
   input  wire                                   csr_index,
   input  wire [rmc_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  wire [rmc_pkg::WORD_W-1:0]             req_random_word,
   input  rmc_pkg::cmd_type                      cmd,
   output rmc_pkg::status_type                   status,
   output logic [$clog2(MAX_WALLS)-1:0]          rsp_wall_index,
   output logic [$clog2(MAX_ROOMS)-1:0]          rsp_room_first,
   output logic [$clog2(MAX_ROOMS)-1:0]          rsp_room_second,
   output logic                                  rsp_wall_removed,
   output logic                                  rsp_maze_done
);

   localparam int WALL_W = $clog2(MAX_WALLS);
   localparam int ROOM_W = $clog2(MAX_ROOMS);
   localparam int CNT_W  = $clog2(MAX_WALLS + 1);
   localparam int RCNT_W = $clog2(MAX_ROOMS + 1);
   localparam int GRD_W  = $clog2(MAX_ROOMS + 1);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int DIV_W  = CNT_W;
   localparam int CLR_N  = (MAX_WALLS > MAX_ROOMS) ? MAX_WALLS : MAX_ROOMS;
   localparam int CLR_W  = $clog2(CLR_N);
   localparam int SZ_W   = 2 * SIDE_W + 2;
   localparam int PW     = WALL_W + SIDE_W + 1;
   localparam int WW     = rmc_pkg::WORD_W;

   logic [rmc_pkg::CSR_DATA_W-1:0] height_ff, width_ff;
   logic [SIDE_W-1:0]  eff_h, eff_w;
   logic [SZ_W-1:0]    rooms_raw, walls_raw;
   logic [RCNT_W-1:0]  rooms_cl;
   logic [CNT_W-1:0]   walls_cl;

   logic [CLR_W-1:0]   clr_ff, clr_in;
   logic [RCNT_W-1:0]  rooms_ff, rooms_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [RCNT_W-1:0]  removed_ff, removed_in;
   logic [WW-1:0]      word_ff, word_in;

   logic [WW-1:0]      quo_ff, quo_in;
   logic [DIV_W-1:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIV_W:0]     div_t;
   logic [rmc_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;

   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [WALL_W-1:0]  wall_ff, wall_in;
   logic [ROOM_W-1:0]  first_ff, first_in, second_ff, second_in;
   logic [ROOM_W-1:0]  p_ff, p_in, root1_ff, root1_in;
   logic [GRD_W-1:0]   guard_ff, guard_in, g1_ff, g1_in;
   logic               rmv_ff, rmv_in, done_ff, done_in;
   logic [CNT_W-1:0]   sh_ff, sh_in;
   logic               pend_ff, pend_in;
   logic [WALL_W-1:0]  waddr_ff, waddr_in;

   logic [PW-1:0]      prod, first_full, second_full;
   logic               vert, find_stop, sh_more;

   logic               w_we, p_we;
   logic [WALL_W-1:0]  w_waddr, w_wdata, w_raddr, w_rdata;
   logic [ROOM_W-1:0]  p_waddr, p_wdata, p_raddr, p_rdata;

   // Size registers; a write restarts the carve through the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= rmc_pkg::HEIGHT_RST;
         width_ff  <= rmc_pkg::WIDTH_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            rmc_pkg::CSR_HEIGHT: height_ff <= csr_write_data;
            rmc_pkg::CSR_WIDTH:  width_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (height_ff == '0)
         eff_h = SIDE_W'(1);
      else if (32'(height_ff) > MAX_SIDE)
         eff_h = SIDE_W'(MAX_SIDE);
      else
         eff_h = SIDE_W'(height_ff);
      if (width_ff == '0)
         eff_w = SIDE_W'(1);
      else if (32'(width_ff) > MAX_SIDE)
         eff_w = SIDE_W'(MAX_SIDE);
      else
         eff_w = SIDE_W'(width_ff);
      rooms_raw = SZ_W'(eff_h) * SZ_W'(eff_w);
      walls_raw = (rooms_raw << 1) - SZ_W'(eff_h) - SZ_W'(eff_w);
      rooms_cl  = (32'(rooms_raw) > MAX_ROOMS) ? RCNT_W'(MAX_ROOMS) : RCNT_W'(rooms_raw);
      walls_cl  = (32'(walls_raw) > MAX_WALLS) ? CNT_W'(MAX_WALLS) : CNT_W'(walls_raw);
   end

   assign div_t = {rem_ff, quo_ff[WW-1]};

   always_comb begin
      prod = PW'(quo_ff[WALL_W-1:0]) * PW'(eff_w);
      vert = rem_ff < (DIV_W'(eff_w) - DIV_W'(1));
      if (vert) begin
         first_full  = prod + PW'(rem_ff);
         second_full = first_full + PW'(1);
      end else begin
         first_full  = prod + PW'(rem_ff) - PW'(eff_w) + PW'(1);
         second_full = first_full + PW'(eff_w);
      end
   end

   assign find_stop = (p_rdata == p_ff) || (guard_ff == GRD_W'(MAX_ROOMS));
   assign sh_more   = sh_ff < count_ff;

   always_comb begin
      clr_in     = clr_ff;
      rooms_in   = rooms_ff;
      count_in   = count_ff;
      removed_in = removed_ff;
      word_in    = word_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      dcnt_in    = dcnt_ff;
      pos_in     = pos_ff;
      wall_in    = wall_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      p_in       = p_ff;
      root1_in   = root1_ff;
      guard_in   = guard_ff;
      g1_in      = g1_ff;
      rmv_in     = rmv_ff;
      done_in    = done_ff;
      sh_in      = sh_ff;
      pend_in    = pend_ff;
      waddr_in   = waddr_ff;

      w_we    = 1'b0;
      w_waddr = waddr_ff;
      w_wdata = w_rdata;
      w_raddr = sh_ff[WALL_W-1:0];
      p_we    = 1'b0;
      p_waddr = root1_ff;
      p_wdata = p_ff;
      p_raddr = p_rdata;

      if (cmd.clr_step) begin
         clr_in  = clr_ff + CLR_W'(1);
         w_we    = 32'(clr_ff) < MAX_WALLS;
         w_waddr = WALL_W'(clr_ff);
         w_wdata = WALL_W'(clr_ff);
         p_we    = 32'(clr_ff) < MAX_ROOMS;
         p_waddr = ROOM_W'(clr_ff);
         p_wdata = ROOM_W'(clr_ff);
         if (32'(clr_ff) == CLR_N - 1) begin
            rooms_in   = rooms_cl;
            count_in   = walls_cl;
            removed_in = '0;
         end
      end
      if (cmd.capture) begin
         word_in = req_random_word;
      end
      if (cmd.resp_blank) begin
         wall_in   = '0;
         first_in  = '0;
         second_in = '0;
         rmv_in    = 1'b0;
         done_in   = status.done_hit;
      end
      if (cmd.div_load_word) begin
         quo_in  = word_ff;
         rem_in  = '0;
         dvs_in  = count_ff;
         dcnt_in = '0;
      end
      if (cmd.div_load_wall) begin
         wall_in = w_rdata;
         quo_in  = WW'(w_rdata);
         rem_in  = '0;
         dvs_in  = (DIV_W'(eff_w) << 1) - DIV_W'(1);
         dcnt_in = '0;
      end
      if (cmd.div_step) begin
         dcnt_in = dcnt_ff + rmc_pkg::DCNT_W'(1);
         if (div_t >= {1'b0, dvs_ff}) begin
            rem_in = DIV_W'(div_t - {1'b0, dvs_ff});
            quo_in = {quo_ff[WW-2:0], 1'b1};
         end else begin
            rem_in = DIV_W'(div_t);
            quo_in = {quo_ff[WW-2:0], 1'b0};
         end
      end
      if (cmd.wall_read) begin
         w_raddr = rem_ff[WALL_W-1:0];
         pos_in  = rem_ff;
      end
      if (cmd.rooms) begin
         first_in  = ROOM_W'(first_full);
         second_in = ROOM_W'(second_full);
      end
      if (cmd.find_load_first) begin
         p_in     = first_ff;
         guard_in = '0;
         p_raddr  = first_ff;
      end
      if (cmd.find_load_second) begin
         p_in     = second_ff;
         guard_in = '0;
         p_raddr  = second_ff;
      end
      if (cmd.find_step && !find_stop) begin
         p_in     = p_rdata;
         guard_in = guard_ff + GRD_W'(1);
      end
      if (cmd.save_root1) begin
         root1_in = p_ff;
         g1_in    = guard_ff;
      end
      if (cmd.union_do) begin
         rmv_in  = 1'b0;
         done_in = 1'b0;
         if (root1_ff != p_ff) begin
            // The shallower root goes under the deeper one; a tie keeps the first root on top.
            p_we = 1'b1;
            if (g1_ff < guard_ff) begin
               p_waddr = root1_ff;
               p_wdata = p_ff;
            end else begin
               p_waddr = p_ff;
               p_wdata = root1_ff;
            end
            rmv_in     = 1'b1;
            removed_in = removed_ff + RCNT_W'(1);
            done_in    = (removed_ff + RCNT_W'(1)) >= (rooms_ff - RCNT_W'(1));
         end
      end
      if (cmd.shift_init) begin
         sh_in   = pos_ff + CNT_W'(1);
         pend_in = 1'b0;
      end
      if (cmd.shift_step) begin
         // Read one entry ahead and write it one place lower in the next cycle.
         w_we    = pend_ff;
         pend_in = sh_more;
         if (sh_more) begin
            waddr_in = WALL_W'(sh_ff - CNT_W'(1));
            sh_in    = sh_ff + CNT_W'(1);
         end
      end
      if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (csr_write_enable) begin
         clr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         rooms_ff   <= '0;
         count_ff   <= '0;
         removed_ff <= '0;
         dcnt_ff    <= '0;
         pend_ff    <= 1'b0;
      end else begin
         clr_ff     <= clr_in;
         rooms_ff   <= rooms_in;
         count_ff   <= count_in;
         removed_ff <= removed_in;
         dcnt_ff    <= dcnt_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      pos_ff    <= pos_in;
      wall_ff   <= wall_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      p_ff      <= p_in;
      root1_ff  <= root1_in;
      guard_ff  <= guard_in;
      g1_ff     <= g1_in;
      rmv_ff    <= rmv_in;
      done_ff   <= done_in;
      sh_ff     <= sh_in;
      waddr_ff  <= waddr_in;
   end

   rmc_ram #(.WIDTH(WALL_W), .DEPTH(MAX_WALLS)) u_walls (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   rmc_ram #(.WIDTH(ROOM_W), .DEPTH(MAX_ROOMS)) u_parent (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   always_comb begin
      status.cfg_write  = csr_write_enable;
      status.clr_last   = 32'(clr_ff) == CLR_N - 1;
      status.done_hit   = removed_ff >= (rooms_ff - RCNT_W'(1));
      status.list_empty = count_ff == '0;
      status.div_last   = dcnt_ff == {rmc_pkg::DCNT_W{1'b1}};
      status.find_stop  = find_stop;
      status.maze_done  = done_ff;
      status.shift_done = !sh_more && !pend_ff;
   end

   assign rsp_wall_index   = wall_ff;
   assign rsp_room_first   = first_ff;
   assign rsp_room_second  = second_ff;
   assign rsp_wall_removed = rmv_ff;
   assign rsp_maze_done    = done_ff;

endmodule
`default_nettype wire

// ===== rtl/rmc_ctrl.sv =====
`default_nettype none
module rmc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  rmc_pkg::status_type   status,
   output rmc_pkg::cmd_type      cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_CHECK  = 5'd2;
   localparam logic [4:0] S_DIVA   = 5'd3;
   localparam logic [4:0] S_WREAD  = 5'd4;
   localparam logic [4:0] S_WWAIT  = 5'd5;
   localparam logic [4:0] S_DIVB   = 5'd6;
   localparam logic [4:0] S_ROOMS  = 5'd7;
   localparam logic [4:0] S_FLOAD1 = 5'd8;
   localparam logic [4:0] S_FIND1  = 5'd9;
   localparam logic [4:0] S_FLOAD2 = 5'd10;
   localparam logic [4:0] S_FIND2  = 5'd11;
   localparam logic [4:0] S_UNION  = 5'd12;
   localparam logic [4:0] S_DECIDE = 5'd13;
   localparam logic [4:0] S_SHIFTI = 5'd14;
   localparam logic [4:0] S_SHIFT  = 5'd15;
   localparam logic [4:0] S_RESP   = 5'd16;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.done_hit || status.list_empty) begin
               cmd.resp_blank = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.div_load_word = 1'b1;
               state_in          = S_DIVA;
            end
         end
         S_DIVA: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_WREAD;
         end
         S_WREAD: begin
            cmd.wall_read = 1'b1;
            state_in      = S_WWAIT;
         end
         S_WWAIT: begin
            cmd.div_load_wall = 1'b1;
            state_in          = S_DIVB;
         end
         S_DIVB: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_ROOMS;
         end
         S_ROOMS: begin
            cmd.rooms = 1'b1;
            state_in  = S_FLOAD1;
         end
         S_FLOAD1: begin
            cmd.find_load_first = 1'b1;
            state_in            = S_FIND1;
         end
         S_FIND1: begin
            cmd.find_step = 1'b1;
            if (status.find_stop) begin
               cmd.save_root1 = 1'b1;
               state_in       = S_FLOAD2;
            end
         end
         S_FLOAD2: begin
            cmd.find_load_second = 1'b1;
            state_in             = S_FIND2;
         end
         S_FIND2: begin
            cmd.find_step = 1'b1;
            if (status.find_stop) state_in = S_UNION;
         end
         S_UNION: begin
            cmd.union_do = 1'b1;
            state_in     = S_DECIDE;
         end
         S_DECIDE: begin
            // The wall of the final removal stays in the list.
            state_in = status.maze_done ? S_RESP : S_SHIFTI;
         end
         S_SHIFTI: begin
            cmd.shift_init = 1'b1;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (status.shift_done) begin
               cmd.count_dec = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      if (status.cfg_write) state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

endmodule
`default_nettype wire

// ===== rtl/random_maze_carver_union_find_top.sv =====
// The result strobe follows the start transfer after two 32-step serial divisions, the
// union-find walks of path lengths d1 and d2, one parent read per cycle, and the wall
// list shift over L - pos entries, one entry per cycle.
// Words are handled one at a time: a new word is taken only while busy is low. The reset
// size is 8 by 8 rooms and the largest size is 64 by 64.
// Reset and every size register write run a clearing pass over both memories with busy
// high; the receiver cannot stall the result transfer.
`default_nettype none
module random_maze_carver_union_find_top #(
   parameter int MAX_SIDE  = rmc_pkg::MAX_SIDE_DEF,
   parameter int MAX_WALLS = rmc_pkg::MAX_WALLS_DEF,
   parameter int MAX_ROOMS = rmc_pkg::MAX_ROOMS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire [rmc_pkg::WORD_W-1:0]             req_random_word,
   output logic                                  rsp_valid,
   output logic [$clog2(MAX_WALLS)-1:0]          rsp_wall_index,
   output logic [$clog2(MAX_ROOMS)-1:0]          rsp_room_first,
   output logic [$clog2(MAX_ROOMS)-1:0]          rsp_room_second,
   output logic                                  rsp_wall_removed,
   output logic                                  rsp_maze_done,
   input  wire                                   csr_write_enable,
   input  wire                                   csr_index,
   input  wire [rmc_pkg::CSR_DATA_W-1:0]         csr_write_data
);

   rmc_pkg::cmd_type    cmd;
   rmc_pkg::status_type status;

   rmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rmc_dpath #(
      .MAX_SIDE  (MAX_SIDE),
      .MAX_WALLS (MAX_WALLS),
      .MAX_ROOMS (MAX_ROOMS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_random_word  (req_random_word),
      .cmd              (cmd),
      .status           (status),
      .rsp_wall_index   (rsp_wall_index),
      .rsp_room_first   (rsp_room_first),
      .rsp_room_second  (rsp_room_second),
      .rsp_wall_removed (rsp_wall_removed),
      .rsp_maze_done    (rsp_maze_done)
   );

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !csr_write_enable) |=> busy)
      else $error("accepted word did not make the block busy");

   a_removed_distinct: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wall_removed) |-> (rsp_room_first != rsp_room_second))
      else $error("removed wall joins a room to itself");

   a_done_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_maze_done && !rsp_wall_removed) |-> (rsp_wall_index == '0))
      else $error("word after completion reported a wall");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

   localparam int MAX_SIDE  = rmc_pkg::MAX_SIDE_DEF;
   localparam int MAX_WALLS = rmc_pkg::MAX_WALLS_DEF;
   localparam int MAX_ROOMS = rmc_pkg::MAX_ROOMS_DEF;

   typedef struct {
      bit              is_cfg;
      logic            reg_sel;
      logic [6:0]      reg_data;
      logic [31:0]     word;
   } stim_op_type;

   typedef struct {
      logic [12:0] wall_index;
      logic [11:0] room_first;
      logic [11:0] room_second;
      logic        wall_removed;
      logic        maze_done;
   } carve_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_random_word = '0;
   logic        rsp_valid;
   logic [12:0] rsp_wall_index;
   logic [11:0] rsp_room_first;
   logic [11:0] rsp_room_second;
   logic        rsp_wall_removed;
   logic        rsp_maze_done;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = rmc_pkg::CSR_HEIGHT;
   logic [6:0]  csr_write_data = '0;

   random_maze_carver_union_find_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_random_word(req_random_word),
      .rsp_valid(rsp_valid), .rsp_wall_index(rsp_wall_index),
      .rsp_room_first(rsp_room_first), .rsp_room_second(rsp_room_second),
      .rsp_wall_removed(rsp_wall_removed), .rsp_maze_done(rsp_maze_done),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   // Mirror of the carving state.
   int unsigned height_reg, width_reg, eff_h, eff_w;
   int unsigned wall_list [MAX_WALLS];
   int unsigned parent_of [MAX_ROOMS];
   int unsigned walls_left, walls_removed;

   stim_op_type      pending_ops[$];
   carve_result_type carve_expect[$];
   int               error_count = 0;
   int               words_sent = 0, results_seen = 0, opened_seen = 0, done_seen = 0;
   int               cfg_writes = 0;

   function automatic int unsigned clamp_side(int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
   endfunction

   function automatic void maze_restart();
      int unsigned walls, rooms;
      eff_h = clamp_side(height_reg);
      eff_w = clamp_side(width_reg);
      walls = eff_h * (eff_w - 1) + eff_w * (eff_h - 1);
      rooms = eff_h * eff_w;
      if (walls > MAX_WALLS) walls = MAX_WALLS;
      if (rooms > MAX_ROOMS) rooms = MAX_ROOMS;
      for (int i = 0; i < MAX_WALLS; i++) wall_list[i] = i;
      for (int i = 0; i < MAX_ROOMS; i++) parent_of[i] = i;
      walls_left = walls;
      walls_removed = 0;
   endfunction

   // Depth counts the starting room as one.
   function automatic int unsigned root_of(int unsigned room, output int unsigned depth);
      int unsigned p, guard;
      p = room;
      depth = 1;
      guard = 0;
      while (parent_of[p] != p && guard < MAX_ROOMS) begin
         p = parent_of[p] % MAX_ROOMS;
         depth++;
         guard++;
      end
      return p;
   endfunction

   function automatic void carve_step(logic [31:0] word);
      carve_result_type res;
      int unsigned need, pos, wall, q, r, first, second, d1, d2, r1, r2;
      need = eff_h * eff_w - 1;
      res = '{default: '0};
      if (walls_removed >= need) begin
         res.maze_done = 1'b1;
      end else if (walls_left != 0) begin
         pos = word % walls_left;
         wall = wall_list[pos];
         q = wall / (2 * eff_w - 1);
         r = wall % (2 * eff_w - 1);
         if (r < eff_w - 1) begin
            first = q * eff_w + r;
            second = first + 1;
         end else begin
            first = q * eff_w + (r - (eff_w - 1));
            second = first + eff_w;
         end
         first = first % MAX_ROOMS;
         second = second % MAX_ROOMS;
         r1 = root_of(first, d1);
         r2 = root_of(second, d2);
         if (r1 != r2) begin
            if (d1 < d2) parent_of[r1] = r2;
            else parent_of[r2] = r1;
            res.wall_removed = 1'b1;
            walls_removed++;
            if (walls_removed >= need) res.maze_done = 1'b1;
         end
         // The final opened wall stays in the list.
         if (!res.maze_done) begin
            for (int unsigned i = pos; i + 1 < walls_left; i++) wall_list[i] = wall_list[i + 1];
            walls_left--;
         end
         res.wall_index = wall[12:0];
         res.room_first = first[11:0];
         res.room_second = second[11:0];
      end
      carve_expect = {carve_expect, res};
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Driver: words go out in bursts; a size write waits until the block is idle.
   int hold_cnt = 0, gap_cnt = 0, burst_left = 1;
   bit cfg_fire = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_write_enable <= 1'b0;
         height_reg = rmc_pkg::HEIGHT_RST;
         width_reg = rmc_pkg::WIDTH_RST;
         maze_restart();
         hold_cnt = 4;
      end else begin
         cfg_fire = 1'b0;
         if (start && !busy) begin
            carve_step(req_random_word);
            words_sent++;
         end
         if (!(start && busy)) begin
            if (hold_cnt > 0) begin
               hold_cnt--;
               start <= 1'b0;
            end else if (gap_cnt > 0) begin
               gap_cnt--;
               start <= 1'b0;
            end else if (pending_ops.size() == 0) begin
               start <= 1'b0;
            end else if (pending_ops[0].is_cfg) begin
               start <= 1'b0;
               if (!start && !busy && carve_expect.size() == 0) begin
                  cfg_fire = 1'b1;
                  csr_index <= pending_ops[0].reg_sel;
                  csr_write_data <= pending_ops[0].reg_data;
                  if (pending_ops[0].reg_sel == rmc_pkg::CSR_HEIGHT)
                     height_reg = pending_ops[0].reg_data;
                  else
                     width_reg = pending_ops[0].reg_data;
                  maze_restart();
                  cfg_writes++;
                  void'(pending_ops.pop_front());
                  hold_cnt = 4;
               end
            end else begin
               start <= 1'b1;
               req_random_word <= pending_ops[0].word;
               void'(pending_ops.pop_front());
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
               end
            end
         end
         csr_write_enable <= cfg_fire;
      end
   end

   // Monitor: every strobe is one transfer and must match the oldest prediction.
   always @(posedge clock) begin
      carve_result_type want;
      if (!reset && rsp_valid) begin
         if (carve_expect.size() == 0) begin
            $display("%0t result transfer with nothing expected", $time);
            error_count++;
         end else begin
            want = carve_expect.pop_front();
            results_seen++;
            if (rsp_wall_removed) opened_seen++;
            if (rsp_maze_done) done_seen++;
            if (rsp_wall_index !== want.wall_index)
               report_mismatch("wall_index", rsp_wall_index, want.wall_index);
            if (rsp_room_first !== want.room_first)
               report_mismatch("room_first", rsp_room_first, want.room_first);
            if (rsp_room_second !== want.room_second)
               report_mismatch("room_second", rsp_room_second, want.room_second);
            if (rsp_wall_removed !== want.wall_removed)
               report_mismatch("wall_removed", rsp_wall_removed, want.wall_removed);
            if (rsp_maze_done !== want.maze_done)
               report_mismatch("maze_done", rsp_maze_done, want.maze_done);
         end
      end
   end

   task automatic add_size(input int unsigned h, input int unsigned w);
      stim_op_type op;
      op = '{1'b1, rmc_pkg::CSR_HEIGHT, h[6:0], '0};
      pending_ops = {pending_ops, op};
      op = '{1'b1, rmc_pkg::CSR_WIDTH, w[6:0], '0};
      pending_ops = {pending_ops, op};
   endtask

   task automatic add_word(input logic [31:0] word);
      stim_op_type op;
      op = '{1'b0, rmc_pkg::CSR_HEIGHT, '0, word};
      pending_ops = {pending_ops, op};
   endtask

   initial begin
      int unsigned h, w, n, rnd_words;
      // Directed: default size with extreme words, then the odd sizes.
      add_word(32'h0000_0000);
      add_word(32'hFFFF_FFFF);
      add_word(32'hAAAA_AAAA);
      add_word(32'h5555_5555);
      add_size(1, 1);                // single room is finished from the start
      add_word(32'h1234_5678);
      add_size(0, 0);                // zero acts as one
      add_word(32'hFFFF_FFFF);
      add_size(1, 2);                // one wall: open it, then words after done
      add_word(32'h0);
      add_word(32'h7);
      add_size(2, 1);
      add_word(32'h8000_0000);
      add_size(2, 2);
      repeat (5) add_word($urandom);
      add_size(127, 2);              // clamped height
      add_word(32'hFFFF_FFFF);
      add_word(32'h0);
      add_size(64, 64);
      add_word(32'h0);
      add_word(32'hFFFF_FFFF);
      // Random: mostly small mazes carved to completion, a few large ones.
      rnd_words = 0;
      while (rnd_words < 80) begin
         case ($urandom_range(0, 9))
            0: begin h = $urandom_range(0, 127); w = $urandom_range(0, 127); n = 3; end
            1: begin h = 64; w = $urandom_range(1, 64); n = 2; end
            default: begin
               h = $urandom_range(1, 5);
               w = $urandom_range(1, 5);
               n = h * (w - 1) + w * (h - 1) + $urandom_range(0, 2);
            end
         endcase
         add_size(h, w);
         repeat (n) begin
            add_word($urandom);
            rnd_words++;
         end
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_ops.size() != 0 || start || carve_expect.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d words over %0d size writes; checked %0d results.",
               words_sent, cfg_writes, results_seen);
      $display("Walls opened: %0d, results marked done: %0d.", opened_seen, done_seen);
      if (error_count == 0 && carve_expect.size() == 0)
         $display("[random_maze_carver_union_find_top] OK");
      else
         $display("[random_maze_carver_union_find_top] ERROR");
      $finish;
   end

   initial begin
      #50ms;
      $display("Timeout with %0d results outstanding.", carve_expect.size());
      $display("[random_maze_carver_union_find_top] ERROR");
      $finish;
   end

endmodule
